[rtl/wsru_pkg.sv]
// shared types and constants for the websocket frame receiver
package wsru_pkg;

  localparam logic [3:0] OPCODE_MASK   = 4'hF;
  localparam logic [6:0] LEN_MASK      = 7'h7F;
  localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
  localparam logic [6:0] LEN_CODE_16   = 7'd126;
  localparam logic [3:0] OPC_CLOSE     = 4'd8;
  localparam logic [3:0] OPC_PING      = 4'd9;
  localparam int unsigned STATUS_NORMAL   = 1000;
  localparam int unsigned STATUS_PROTOCOL = 1002;

  typedef enum logic [1:0] {
    KIND_HEADER   = 2'd0,
    KIND_DATA     = 2'd1,
    KIND_RSV_ERR  = 2'd2,
    KIND_MASK_ERR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REPLY_NONE           = 2'd0,
    REPLY_CLOSE_NORMAL   = 2'd1,
    REPLY_PONG           = 2'd2,
    REPLY_CLOSE_PROTOCOL = 2'd3
  } reply_t;

  typedef struct packed {
    kind_t       kind;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic [31:0] payload_length;
    logic [7:0]  out_byte;
    logic        last_byte;
    reply_t      reply;
  } res_t;

endpackage

[rtl/wsru_parse.sv]
// frame header parser and payload unmasker, one byte per accepted word
module wsru_parse
  import wsru_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output logic       res_valid,
  output res_t       res
);

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_LEN16 = 3'd2,
    PH_LEN64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  byte_counter, byte_counter_next;
  logic        fin_reg, fin_reg_next;
  logic [3:0]  opcode_reg, opcode_reg_next;
  logic [31:0] remaining, remaining_next;
  logic [31:0] key_reg, key_reg_next;
  logic [1:0]  key_index, key_index_next;

  logic [2:0]  cnt_inc;
  logic [6:0]  len_code;
  logic [31:0] rem_dec;
  logic [7:0]  key_byte;

  assign cnt_inc  = byte_counter + 3'd1;
  assign len_code = in_byte[6:0] & LEN_MASK;
  assign rem_dec  = remaining - 32'd1;
  // key byte 0 sits in bits 31..24
  assign key_byte = key_reg[{~key_index, 3'b000} +: 8];

  always_comb begin
    phase_next        = phase;
    byte_counter_next = byte_counter;
    fin_reg_next      = fin_reg;
    opcode_reg_next   = opcode_reg;
    remaining_next    = remaining;
    key_reg_next      = key_reg;
    key_index_next    = key_index;
    res_valid         = 1'b0;
    res.kind           = KIND_HEADER;
    res.fin_flag       = fin_reg;
    res.frame_opcode   = opcode_reg;
    res.payload_length = '0;
    res.out_byte       = '0;
    res.last_byte      = 1'b0;
    res.reply          = REPLY_NONE;

    case (phase)
      PH_HDR1: begin
        if (!in_byte[7]) begin
          res_valid  = 1'b1;
          res.kind   = KIND_MASK_ERR;
          res.reply  = REPLY_CLOSE_PROTOCOL;
          phase_next = PH_HDR0;
        end else begin
          byte_counter_next = '0;
          key_reg_next      = '0;
          if (len_code <= LEN_SHORT_MAX) begin
            remaining_next = {25'd0, len_code};
            phase_next     = PH_KEY;
          end else begin
            remaining_next = '0;
            phase_next     = (len_code == LEN_CODE_16) ? PH_LEN16 : PH_LEN64;
          end
        end
      end

      PH_LEN16, PH_LEN64: begin
        remaining_next    = {remaining[23:0], in_byte};
        byte_counter_next = cnt_inc;
        // eight length bytes wrap the counter back to zero
        if ((phase == PH_LEN16 && cnt_inc == 3'd2) ||
            (phase == PH_LEN64 && cnt_inc == 3'd0)) begin
          byte_counter_next = '0;
          phase_next        = PH_KEY;
        end
      end

      PH_KEY: begin
        key_reg_next      = {key_reg[23:0], in_byte};
        byte_counter_next = cnt_inc;
        if (cnt_inc >= 3'd4) begin
          byte_counter_next  = '0;
          key_index_next     = '0;
          res_valid          = 1'b1;
          res.kind           = KIND_HEADER;
          res.payload_length = remaining;
          if (opcode_reg == OPC_CLOSE) begin
            res.reply = REPLY_CLOSE_NORMAL;
          end else if (opcode_reg == OPC_PING) begin
            res.reply = REPLY_PONG;
          end
          phase_next = (remaining == '0) ? PH_HDR0 : PH_DATA;
        end
      end

      PH_DATA: begin
        key_index_next = key_index + 2'd1;
        remaining_next = rem_dec;
        res_valid      = 1'b1;
        res.kind       = KIND_DATA;
        res.out_byte   = in_byte ^ key_byte;
        res.last_byte  = (rem_dec == '0);
        if (rem_dec == '0) begin
          phase_next = PH_HDR0;
        end
      end

      default: begin
        if (in_byte[6:4] != 3'b000) begin
          res_valid        = 1'b1;
          res.kind         = KIND_RSV_ERR;
          res.fin_flag     = in_byte[7];
          res.frame_opcode = in_byte[3:0] & OPCODE_MASK;
          phase_next       = PH_HDR0;
        end else begin
          fin_reg_next    = in_byte[7];
          opcode_reg_next = in_byte[3:0] & OPCODE_MASK;
          phase_next      = PH_HDR1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      byte_counter <= '0;
      fin_reg      <= 1'b0;
      opcode_reg   <= '0;
      remaining    <= '0;
      key_reg      <= '0;
      key_index    <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      byte_counter <= byte_counter_next;
      fin_reg      <= fin_reg_next;
      opcode_reg   <= opcode_reg_next;
      remaining    <= remaining_next;
      key_reg      <= key_reg_next;
      key_index    <= key_index_next;
    end
  end

endmodule

[rtl/wsru_out_reg.sv]
// result register with valid/ready toward the receiver
module wsru_out_reg
  import wsru_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t res_in,
  input  logic out_ready,
  output logic slot_free,
  output logic out_valid,
  output res_t res_out
);

  // free when empty or being drained this cycle
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

[rtl/websocket_frame_receive_unmask.sv]
// top level of the websocket frame receiver and unmasker
// usage:
//   in_valid/in_ready/in_byte carry received bytes, one word per handshake.
//   out_valid/out_ready carry one result word: header done, payload byte
//   (unmasked, last one flagged) or a framing error, with the reply request.
//   header bytes and mask key bytes produce no result word unless a framing
//   error is found; the header result appears with the last key byte.
//   a result is registered, so it is on the outputs in the cycle after its byte is taken.
//   throughput: one byte per cycle unless a held result stalls; parser
//   state updates per taken byte and the result register parts the two
//   sides, so a new byte is taken while the previous result is read out.
//   when the receiver stalls with a result held, in_ready drops until that
//   result is taken; in_ready depends combinationally on out_ready.
//   reset clears the parser to expect a first header byte and empties the
//   result register.
module websocket_frame_receive_unmask
  import wsru_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic        fin_flag,
  output logic [3:0]  frame_opcode,
  output logic [31:0] payload_length,
  output logic [7:0]  out_byte,
  output logic        last_byte,
  output logic [1:0]  reply
);

  logic accept;
  logic res_valid;
  logic slot_free;
  res_t res_c;
  res_t res_q;

  assign in_ready = slot_free;
  assign accept   = in_valid && in_ready;

  wsru_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res_c)
  );

  wsru_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && res_valid),
    .res_in    (res_c),
    .out_ready (out_ready),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  assign kind           = res_q.kind;
  assign fin_flag       = res_q.fin_flag;
  assign frame_opcode   = res_q.frame_opcode;
  assign payload_length = res_q.payload_length;
  assign out_byte       = res_q.out_byte;
  assign last_byte      = res_q.last_byte;
  assign reply          = res_q.reply;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_data_no_reply: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DATA |-> reply == REPLY_NONE)
    else $error("payload word carries a reply request");

  a_last_only_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_byte |-> kind == KIND_DATA)
    else $error("last flag on a non-payload word");

  a_mask_err_reply: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_MASK_ERR |-> reply == REPLY_CLOSE_PROTOCOL)
    else $error("unmasked frame without protocol close");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !accept |=> !out_valid)
    else $error("result repeated after it was taken");

endmodule
